// File: rtl/uist_pkg.sv
// Shared constants, codes and types for the identifier set table.
// No dependencies; imported by uist_cell and unordered_id_set_table.
package uist_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int ID_W     = 32;

  localparam logic [ID_W-1:0] NO_ID = {ID_W{1'b1}};

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_PRESENT = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_RANGE   = 3'd5;

  // Write port broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   data;
  } wr_t;

endpackage

// File: rtl/uist_cell.sv
// One slot of the identifier set: holds an entry and compares it with the key.
// Depends on uist_pkg.
module uist_cell import uist_pkg::*; (
  input  logic               clk,
  input  logic [SLOT_W-1:0]  cell_idx,
  input  logic [COUNT_W-1:0] count,
  input  logic [ID_W-1:0]    key,
  input  wr_t                wr,
  output logic [ID_W-1:0]    entry,
  output logic               match
);

  logic [ID_W-1:0] entry_r;

  always_ff @(posedge clk) begin
    if (wr.en && (wr.slot == cell_idx)) begin
      entry_r <= wr.data;
    end
  end

  // only slots below the fill count take part
  assign match = ({1'b0, cell_idx} < count) && (entry_r == key);
  assign entry = entry_r;

endmodule

// File: rtl/unordered_id_set_table.sv
// Bounded set of 32-bit identifiers held in a row of compare cells.
// Depends on uist_pkg and uist_cell.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one request: add, delete,
//   lookup or read at slot. Result channel (out_valid/out_stall) returns
//   exactly one result per request, with status, slot, identifier read and
//   the count after the request. A transaction completes on a clock edge
//   where valid is high and stall is low.
//   The result is registered when the pending request is evaluated.
//   A new request is taken only once the last one has evaluated. The
//   request register is evaluated once no stalled result is held (all
//   cells compare at once); a delete's swap-with-last write lands in the
//   cycle after that, while the next request is being taken.
//   If the receiver stalls, the result is held and a pending request waits
//   in the request register; in_stall stays high until it has evaluated.
//   Reset (rst_n low, synchronous) empties the set and drops any request
//   or result in flight; the slot contents are not cleared.
module unordered_id_set_table import uist_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [ID_W-1:0]    in_id_value,
  input  logic [SLOT_W-1:0]  in_slot_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [SLOT_W-1:0]  out_found_slot,
  output logic [ID_W-1:0]    out_id_out,
  output logic [COUNT_W-1:0] out_element_count
);

  logic               req_v_r;
  logic [1:0]         req_type_r;
  logic [ID_W-1:0]    id_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r;
  logic [2:0]         status_r, status_nxt;
  logic [SLOT_W-1:0]  found_r, found_nxt;
  logic [ID_W-1:0]    id_out_r, id_out_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [SLOT_W-1:0]  wr_slot_r;
  logic [ID_W-1:0]    wr_data_r;

  logic [ID_W-1:0]     entry_w [CAPACITY];
  logic [CAPACITY-1:0] match_w;
  wr_t                 wr;
  logic                fire;
  logic                accept;
  logic                any_hit;
  logic [SLOT_W-1:0]   hit_slot;
  logic [SLOT_W-1:0]   last_idx;
  logic                add_wr;

  assign fire     = req_v_r && (!out_valid_r || !out_stall);
  assign in_stall = req_v_r;
  assign accept   = in_valid && !in_stall;
  assign any_hit  = |match_w;
  assign last_idx = SLOT_W'(count_r - COUNT_W'(1));

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    uist_cell u_cell (
      .clk      (clk),
      .cell_idx (SLOT_W'(g)),
      .count    (count_r),
      .key      (id_r),
      .wr       (wr),
      .entry    (entry_w[g]),
      .match    (match_w[g])
    );
  end

  // identifiers are unique, so at most one cell matches
  always_comb begin
    hit_slot = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (match_w[k]) hit_slot = hit_slot | SLOT_W'(k);
    end
  end

  always_comb begin
    status_nxt  = ST_OK;
    found_nxt   = '0;
    id_out_nxt  = NO_ID;
    count_nxt   = count_r;
    wr_pend_nxt = 1'b0;
    add_wr      = 1'b0;
    if (req_type_r == REQ_READ) begin
      if ({1'b0, slot_r} < count_r) id_out_nxt = entry_w[slot_r];
      else                          status_nxt = ST_RANGE;
    end else if (id_r == NO_ID) begin
      status_nxt = ST_INVALID;
    end else begin
      unique case (req_type_r)
        REQ_ADD: begin
          if (any_hit) begin
            status_nxt = ST_PRESENT;
            found_nxt  = hit_slot;
          end else if (count_r == COUNT_W'(CAPACITY)) begin
            status_nxt = ST_FULL;
          end else begin
            found_nxt = SLOT_W'(count_r);
            count_nxt = count_r + COUNT_W'(1);
            add_wr    = 1'b1;
          end
        end
        REQ_DELETE: begin
          if (any_hit) begin
            found_nxt   = hit_slot;
            count_nxt   = count_r - COUNT_W'(1);
            wr_pend_nxt = 1'b1;
          end else begin
            status_nxt = ST_MISSING;
          end
        end
        default: begin
          if (any_hit) found_nxt  = hit_slot;
          else         status_nxt = ST_MISSING;
        end
      endcase
    end
  end

  // single write port: the append on evaluation, or the deferred swap-with-last
  always_comb begin
    if (wr_pend_r) begin
      wr.en   = 1'b1;
      wr.slot = wr_slot_r;
      wr.data = wr_data_r;
    end else begin
      wr.en   = fire && add_wr;
      wr.slot = SLOT_W'(count_r);
      wr.data = id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      wr_pend_r   <= 1'b0;
    end else begin
      if (accept)          req_v_r <= 1'b1;
      else if (fire)       req_v_r <= 1'b0;
      if (fire)            count_r <= count_nxt;
      if (fire)            out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      wr_pend_r <= fire && wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= in_req_type;
      id_r       <= in_id_value;
      slot_r     <= in_slot_index;
    end
    if (fire) begin
      status_r  <= status_nxt;
      found_r   <= found_nxt;
      id_out_r  <= id_out_nxt;
      wr_slot_r <= hit_slot;
      wr_data_r <= entry_w[last_idx];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_found_slot    = found_r;
  assign out_id_out        = id_out_r;
  assign out_element_count = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_w))
    else $error("identifier stored in more than one slot");

  a_swap_alone: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> !req_v_r)
    else $error("request evaluated while swap write pending");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("evaluated request produced no result");

endmodule
